@@ design/rmq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

    localparam int DATA_W = 16;
    localparam int FRAC_W = 14;

    localparam int CAND_W = DATA_W + 2;
    localparam int X_W    = CAND_W + FRAC_W - 2;
    localparam int SQ_N   = (X_W + 1) / 2;
    localparam int R_W    = 2 * SQ_N + 1;
    localparam int B_W    = SQ_N + 1;
    localparam int MAG_W  = DATA_W + 1;
    localparam int D_W    = B_W + 2;
    localparam int N_W    = MAG_W + FRAC_W + 1;
    localparam int Q_N    = N_W - FRAC_W - 1;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [1:0] {
        PICK_W,
        PICK_X,
        PICK_Y,
        PICK_Z
    } t_pick;

    typedef struct packed {
        t_data m_xx;
        t_data m_xy;
        t_data m_xz;
        t_data m_yx;
        t_data m_yy;
        t_data m_yz;
        t_data m_zx;
        t_data m_zy;
        t_data m_zz;
    } t_mat;

    typedef struct packed {
        t_data q_x;
        t_data q_y;
        t_data q_z;
        t_data q_w;
    } t_quat;

    // three non-chosen components, in output order
    typedef struct packed {
        t_pick                  pick;
        logic [2:0]             neg;
        logic [2:0][MAG_W-1:0]  mag;
    } t_side;

endpackage
`default_nettype wire

@@ design/rmq_mat_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rmq_mat_if;
    import rmq_pkg::*;

    logic valid;
    logic ready;
    t_mat data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/rmq_quat_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rmq_quat_if;
    import rmq_pkg::*;

    logic  valid;
    logic  ready;
    t_quat data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/rmq_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  wire [rmq_pkg::X_W-1:0]   i_x,
    input  rmq_pkg::t_side           i_side,
    output logic                     o_valid,
    output logic [rmq_pkg::B_W-1:0]  o_b,
    output rmq_pkg::t_side           o_side
);
    import rmq_pkg::*;

    typedef struct packed {
        logic [R_W-1:0] x;
        logic [R_W-1:0] res;
        t_side          side;
    } t_sq;

    t_sq            r_s [SQ_N];
    t_sq            n_s [SQ_N];
    logic [SQ_N:0]  r_v;
    logic [B_W-1:0] r_b;
    logic [B_W-1:0] n_b;
    t_side          r_side;
    logic [R_W-1:0] s_x;
    logic [R_W-1:0] s_res;
    logic [R_W-1:0] s_bit;
    logic [R_W-1:0] s_t;

    // one result bit per stage
    always_comb begin
        for (int k = 0; k < SQ_N; k++) begin
            if (k == 0) begin
                s_x            = R_W'(i_x);
                s_res          = '0;
                n_s[k].side    = i_side;
            end else begin
                s_x            = r_s[k-1].x;
                s_res          = r_s[k-1].res;
                n_s[k].side    = r_s[k-1].side;
            end
            s_bit = R_W'(1) << (2 * (SQ_N - 1 - k));
            s_t   = s_res + s_bit;
            if (s_x >= s_t) begin
                n_s[k].x   = s_x - s_t;
                n_s[k].res = (s_res >> 1) + s_bit;
            end else begin
                n_s[k].x   = s_x;
                n_s[k].res = s_res >> 1;
            end
        end
        // round to nearest
        n_b = B_W'(r_s[SQ_N-1].res + R_W'(r_s[SQ_N-1].x > r_s[SQ_N-1].res));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[SQ_N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_N; k++) begin
                r_s[k] <= n_s[k];
            end
            r_b    <= n_b;
            r_side <= r_s[SQ_N-1].side;
        end
    end

    assign o_valid = r_v[SQ_N];
    assign o_b     = r_b;
    assign o_side  = r_side;
endmodule
`default_nettype wire

@@ design/rmq_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rmq_div (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  wire                               i_valid,
    input  wire [rmq_pkg::B_W-1:0]            i_b,
    input  rmq_pkg::t_side                    i_side,
    output logic                              o_valid,
    output logic [rmq_pkg::B_W-1:0]           o_b,
    output rmq_pkg::t_pick                    o_pick,
    output logic [2:0]                        o_neg,
    output logic [2:0][rmq_pkg::Q_N-1:0]      o_q
);
    import rmq_pkg::*;

    typedef struct packed {
        logic [2:0][N_W-1:0] n;
        logic [2:0][D_W-1:0] rem;
        logic [2:0][Q_N-1:0] q;
        logic [D_W-1:0]      den;
        logic [B_W-1:0]      b;
        t_pick               pick;
        logic [2:0]          neg;
    } t_dv;

    t_dv           r_d [Q_N+1];
    t_dv           n_d [Q_N+1];
    logic [Q_N:0]  r_v;
    logic [D_W:0]  s_r2;

    always_comb begin
        // numerator with half divisor added for rounding
        n_d[0].den  = D_W'(i_b) << 2;
        n_d[0].b    = i_b;
        n_d[0].pick = i_side.pick;
        n_d[0].neg  = i_side.neg;
        for (int j = 0; j < 3; j++) begin
            n_d[0].n[j]   = (N_W'(i_side.mag[j]) << FRAC_W) + (N_W'(i_b) << 1);
            n_d[0].rem[j] = D_W'(n_d[0].n[j] >> Q_N);
            n_d[0].q[j]   = '0;
        end
        for (int k = 1; k <= Q_N; k++) begin
            n_d[k] = r_d[k-1];
            for (int j = 0; j < 3; j++) begin
                s_r2 = {r_d[k-1].rem[j], r_d[k-1].n[j][Q_N-k]};
                if (s_r2 >= {1'b0, r_d[k-1].den}) begin
                    n_d[k].rem[j] = D_W'(s_r2 - {1'b0, r_d[k-1].den});
                    n_d[k].q[j]   = {r_d[k-1].q[j][Q_N-2:0], 1'b1};
                end else begin
                    n_d[k].rem[j] = D_W'(s_r2);
                    n_d[k].q[j]   = {r_d[k-1].q[j][Q_N-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Q_N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= Q_N; k++) begin
                r_d[k] <= n_d[k];
            end
        end
    end

    assign o_valid = r_v[Q_N];
    assign o_b     = r_d[Q_N].b;
    assign o_pick  = r_d[Q_N].pick;
    assign o_neg   = r_d[Q_N].neg;
    assign o_q     = r_d[Q_N].q;
endmodule
`default_nettype wire

@@ design/rotation_matrix_to_quaternion_top.sv @@
// rotation matrix to unit quaternion, signed Q2.14 in and out
//
// i_mat (sink): one request carries the nine matrix elements m_xx .. m_zz.
// o_quat (source): one request carries q_x, q_y, q_z, q_w, saturated.
// a transfer happens on a rising clock edge with valid and ready both high.
//
// every matrix yields exactly one quaternion, in order. the block is a
// 37-stage pipeline: two stages form the candidates and pick the largest,
// 16 stages take the square root (one result bit per stage, then a rounding
// register), 18 stages run the three divisions side by side (a load stage,
// then one quotient bit per stage), and a last register saturates and holds
// the result. it takes one matrix per cycle while the receiver does not stall.
//
// the whole pipeline advances together. i_mat.ready is high while the
// output register is empty or being read, so a stalled receiver holds the
// pipeline still and nothing is lost or repeated.
//
// reset (i_rst_n low at a clock edge) clears all valid bits; no data is
// kept between matrices.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rmq_mat_if.sink     i_mat,
    rmq_quat_if.source  o_quat
);
    import rmq_pkg::*;

    localparam logic [X_W-1:0]    X_FLOOR  = X_W'(1) << (2 * FRAC_W - 2);
    localparam logic [Q_N-1:0]    LIM_POS  = (Q_N'(1) << (DATA_W - 1)) - Q_N'(1);
    localparam logic [Q_N-1:0]    LIM_NEG  = Q_N'(1) << (DATA_W - 1);
    localparam logic [CAND_W-1:0] ONE      = CAND_W'(1) << FRAC_W;

    typedef struct packed {
        logic signed [CAND_W-1:0] c_w;
        logic signed [CAND_W-1:0] c_x;
        logic signed [CAND_W-1:0] c_y;
        logic signed [CAND_W-1:0] c_z;
        logic signed [MAG_W-1:0]  d_yz;
        logic signed [MAG_W-1:0]  d_zx;
        logic signed [MAG_W-1:0]  d_xy;
        logic signed [MAG_W-1:0]  p_xy;
        logic signed [MAG_W-1:0]  p_zx;
        logic signed [MAG_W-1:0]  p_yz;
    } t_cand;

    function automatic t_data sat(input logic [Q_N-1:0] mag, input logic neg);
        t_data res;
        if (neg) begin
            if (mag > LIM_NEG) begin
                res = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                res = -t_data'(mag[DATA_W-1:0]);
            end
        end else begin
            if (mag > LIM_POS) begin
                res = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                res = t_data'(mag[DATA_W-1:0]);
            end
        end
        return res;
    endfunction

    logic                      s_en;
    logic                      r_a_v;
    t_cand                     r_a;
    t_cand                     n_a;
    logic                      r_b_v;
    logic [X_W-1:0]            r_bx;
    logic [X_W-1:0]            n_bx;
    t_side                     r_bside;
    t_side                     n_bside;
    logic signed [CAND_W-1:0]  s_best;
    logic signed [MAG_W-1:0]   s_sel [3];
    logic [CAND_W-1:0]         s_v;
    logic                      sq_v;
    logic [B_W-1:0]            sq_b;
    t_side                     sq_side;
    logic                      dv_v;
    logic [B_W-1:0]            dv_b;
    t_pick                     dv_pick;
    logic [2:0]                dv_neg;
    logic [2:0][Q_N-1:0]       dv_q;
    t_data                     s_b;
    t_data                     s_o [3];
    logic                      r_out_v;
    t_quat                     r_out;
    t_quat                     n_out;

    assign s_en        = !r_out_v || o_quat.ready;
    assign i_mat.ready = s_en;

    // candidates and off-diagonal sums and differences
    always_comb begin
        n_a.c_w  = CAND_W'(i_mat.data.m_xx) + CAND_W'(i_mat.data.m_yy)
                 + CAND_W'(i_mat.data.m_zz);
        n_a.c_x  = CAND_W'(i_mat.data.m_xx) - CAND_W'(i_mat.data.m_yy)
                 - CAND_W'(i_mat.data.m_zz);
        n_a.c_y  = CAND_W'(i_mat.data.m_yy) - CAND_W'(i_mat.data.m_xx)
                 - CAND_W'(i_mat.data.m_zz);
        n_a.c_z  = CAND_W'(i_mat.data.m_zz) - CAND_W'(i_mat.data.m_xx)
                 - CAND_W'(i_mat.data.m_yy);
        n_a.d_yz = MAG_W'(i_mat.data.m_yz) - MAG_W'(i_mat.data.m_zy);
        n_a.d_zx = MAG_W'(i_mat.data.m_zx) - MAG_W'(i_mat.data.m_xz);
        n_a.d_xy = MAG_W'(i_mat.data.m_xy) - MAG_W'(i_mat.data.m_yx);
        n_a.p_xy = MAG_W'(i_mat.data.m_xy) + MAG_W'(i_mat.data.m_yx);
        n_a.p_zx = MAG_W'(i_mat.data.m_zx) + MAG_W'(i_mat.data.m_xz);
        n_a.p_yz = MAG_W'(i_mat.data.m_yz) + MAG_W'(i_mat.data.m_zy);
    end

    // largest candidate, earlier wins ties
    always_comb begin
        n_bside.pick = PICK_W;
        s_best       = r_a.c_w;
        if (r_a.c_x > s_best) begin
            s_best       = r_a.c_x;
            n_bside.pick = PICK_X;
        end
        if (r_a.c_y > s_best) begin
            s_best       = r_a.c_y;
            n_bside.pick = PICK_Y;
        end
        if (r_a.c_z > s_best) begin
            s_best       = r_a.c_z;
            n_bside.pick = PICK_Z;
        end
        case (n_bside.pick)
            PICK_X: begin
                s_sel[0] = r_a.p_xy;
                s_sel[1] = r_a.p_zx;
                s_sel[2] = r_a.d_yz;
            end
            PICK_Y: begin
                s_sel[0] = r_a.p_xy;
                s_sel[1] = r_a.p_yz;
                s_sel[2] = r_a.d_zx;
            end
            PICK_Z: begin
                s_sel[0] = r_a.p_zx;
                s_sel[1] = r_a.p_yz;
                s_sel[2] = r_a.d_xy;
            end
            default: begin
                s_sel[0] = r_a.d_yz;
                s_sel[1] = r_a.d_zx;
                s_sel[2] = r_a.d_xy;
            end
        endcase
        for (int j = 0; j < 3; j++) begin
            n_bside.neg[j] = s_sel[j][MAG_W-1];
            n_bside.mag[j] = s_sel[j][MAG_W-1] ? MAG_W'(-s_sel[j]) : MAG_W'(s_sel[j]);
        end
        s_v  = s_best + ONE;
        n_bx = X_W'(s_v) << (FRAC_W - 2);
    end

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (r_b_v),
        .i_x     (r_bx),
        .i_side  (r_bside),
        .o_valid (sq_v),
        .o_b     (sq_b),
        .o_side  (sq_side)
    );

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (sq_v),
        .i_b     (sq_b),
        .i_side  (sq_side),
        .o_valid (dv_v),
        .o_b     (dv_b),
        .o_pick  (dv_pick),
        .o_neg   (dv_neg),
        .o_q     (dv_q)
    );

    // saturate and place components
    always_comb begin
        s_b = sat(Q_N'(dv_b), 1'b0);
        for (int j = 0; j < 3; j++) begin
            s_o[j] = sat(dv_q[j], dv_neg[j]);
        end
        case (dv_pick)
            PICK_X: n_out = '{q_x: s_b,    q_y: s_o[0], q_z: s_o[1], q_w: s_o[2]};
            PICK_Y: n_out = '{q_x: s_o[0], q_y: s_b,    q_z: s_o[1], q_w: s_o[2]};
            PICK_Z: n_out = '{q_x: s_o[0], q_y: s_o[1], q_z: s_b,    q_w: s_o[2]};
            default: n_out = '{q_x: s_o[0], q_y: s_o[1], q_z: s_o[2], q_w: s_b};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (s_en) begin
            r_a_v   <= i_mat.valid;
            r_b_v   <= r_a_v;
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_a     <= n_a;
            r_bx    <= n_bx;
            r_bside <= n_bside;
            r_out   <= n_out;
        end
    end

    assign o_quat.valid = r_out_v;
    assign o_quat.data  = r_out;

    // candidates sum to zero, so the root argument never drops below one quarter
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_v |-> r_bx >= X_FLOOR)
        else $error("root argument below floor");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_v && !r_a_v && !r_b_v)
        else $error("valid bit survived reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_en |=> $stable(r_b_v) && $stable(r_bx) && $stable(r_out))
        else $error("pipeline moved during stall");

    a_div_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_v |-> dv_b >= (B_W'(1) << (FRAC_W - 1)))
        else $error("divisor below one half");
endmodule
`default_nettype wire

@@ test/tb_rotation_matrix_to_quaternion_top.sv @@
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion_top;
    import rmq_pkg::*;

    localparam int LATENCY   = 37;
    localparam int CYCLE_CAP = 400000;
    localparam int HOLD_AT   = 2000;
    localparam longint Q_MAX = 32767;
    localparam longint Q_MIN = -32768;

    logic i_clk;
    logic i_rst_n;

    rmq_mat_if  mat_ch();
    rmq_quat_if quat_ch();

    rotation_matrix_to_quaternion_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat_ch.sink),
        .o_quat  (quat_ch.source)
    );

    t_mat   pending_mats[$];
    t_quat  expected_quats[$];
    int     err_count;
    int     cycle_count;
    int     burst_left;
    int     gap_left;
    int     stall_left;
    int     long_hold;
    bit     long_hold_done;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint isqrt_round(longint x);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= x) r = r + 1;
        // round to nearest, half up: r + 0.5 <= sqrt(x) <=> x > r*r + r
        if (x > r * r + r) r = r + 1;
        return r;
    endfunction

    function automatic longint scaled_quot(longint s, longint b);
        longint mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q = ((mag <<< FRAC_W) + 2 * b) / (4 * b);
        return (s < 0) ? -q : q;
    endfunction

    function automatic t_data sat16(longint v);
        if (v > Q_MAX) v = Q_MAX;
        if (v < Q_MIN) v = Q_MIN;
        return t_data'(v);
    endfunction

    function automatic t_quat quat_of_mat(t_mat m);
        longint xx, xy, xz, yx, yy, yz, zx, zy, zz;
        longint cw, cx, cy, cz, best, b;
        longint qx, qy, qz, qw;
        t_pick pick;
        t_quat q;
        xx = m.m_xx; xy = m.m_xy; xz = m.m_xz;
        yx = m.m_yx; yy = m.m_yy; yz = m.m_yz;
        zx = m.m_zx; zy = m.m_zy; zz = m.m_zz;
        cw = xx + yy + zz;
        cx = xx - yy - zz;
        cy = yy - xx - zz;
        cz = zz - xx - yy;
        pick = PICK_W;
        best = cw;
        if (cx > best) begin best = cx; pick = PICK_X; end
        if (cy > best) begin best = cy; pick = PICK_Y; end
        if (cz > best) begin best = cz; pick = PICK_Z; end
        b = isqrt_round((best + (64'sd1 <<< FRAC_W)) <<< (FRAC_W - 2));
        case (pick)
            PICK_W: begin
                qx = scaled_quot(yz - zy, b); qy = scaled_quot(zx - xz, b);
                qz = scaled_quot(xy - yx, b); qw = b;
            end
            PICK_X: begin
                qx = b; qy = scaled_quot(xy + yx, b);
                qz = scaled_quot(zx + xz, b); qw = scaled_quot(yz - zy, b);
            end
            PICK_Y: begin
                qx = scaled_quot(xy + yx, b); qy = b;
                qz = scaled_quot(yz + zy, b); qw = scaled_quot(zx - xz, b);
            end
            default: begin
                qx = scaled_quot(zx + xz, b); qy = scaled_quot(yz + zy, b);
                qz = b; qw = scaled_quot(xy - yx, b);
            end
        endcase
        q.q_x = sat16(qx);
        q.q_y = sat16(qy);
        q.q_z = sat16(qz);
        q.q_w = sat16(qw);
        return q;
    endfunction

    function automatic t_data rand_elem();
        case ($urandom_range(0, 5))
            0: return t_data'($urandom_range(0, 65535));
            1: return 16'sh7fff;
            2: return 16'sh8000;
            3: return t_data'($signed($urandom_range(0, 32768)) - 16384);
            default: return t_data'($signed($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    // near-rotation: axis-aligned permutation with signs plus small noise
    function automatic t_mat rand_rot();
        t_data e[9];
        int perm[3];
        int t, k, j;
        t_mat m;
        perm[0] = 0; perm[1] = 1; perm[2] = 2;
        for (k = 2; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = perm[k]; perm[k] = perm[j]; perm[j] = t;
        end
        for (k = 0; k < 9; k++)
            e[k] = t_data'($signed($urandom_range(0, 4000)) - 2000);
        for (k = 0; k < 3; k++)
            e[k * 3 + perm[k]] = $urandom_range(0, 1)
                ? t_data'(16384 - $signed($urandom_range(0, 3000)))
                : t_data'(-16384 + $signed($urandom_range(0, 3000)));
        m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return m;
    endfunction

    function automatic t_mat diag_mat(t_data a, t_data b, t_data c);
        t_mat m;
        m = '0;
        m.m_xx = a; m.m_yy = b; m.m_zz = c;
        return m;
    endfunction

    initial begin
        t_mat m;
        int k;
        // identity and rotations by pi about each axis pick each component
        pending_mats.push_back(diag_mat(16384, 16384, 16384));
        pending_mats.push_back(diag_mat(16384, -16384, -16384));
        pending_mats.push_back(diag_mat(-16384, 16384, -16384));
        pending_mats.push_back(diag_mat(-16384, -16384, 16384));
        // ties between candidates
        pending_mats.push_back(diag_mat(0, 0, 0));
        pending_mats.push_back(diag_mat(16384, 0, 0));
        pending_mats.push_back(diag_mat(0, 16384, 0));
        pending_mats.push_back(diag_mat(-16384, -16384, -16384));
        // field extremes, saturating results
        pending_mats.push_back('1);
        pending_mats.push_back({9{16'sh7fff}});
        pending_mats.push_back({9{16'sh8000}});
        pending_mats.push_back(diag_mat(16'sh8000, 16'sh8000, 16'sh8000));
        pending_mats.push_back(diag_mat(16'sh7fff, 16'sh8000, 16'sh8000));
        m = diag_mat(0, 0, 0);
        m.m_xy = 16'sh7fff; m.m_yx = 16'sh8000; m.m_yz = 16'sh7fff;
        m.m_zy = 16'sh8000; m.m_zx = 16'sh7fff; m.m_xz = 16'sh8000;
        pending_mats.push_back(m);
        m.m_xy = 16'sh8000; m.m_yx = 16'sh7fff; m.m_yz = 16'sh8000;
        m.m_zy = 16'sh7fff; m.m_zx = 16'sh8000; m.m_xz = 16'sh7fff;
        pending_mats.push_back(m);
        // 90 degrees about z
        m = diag_mat(0, 0, 16384);
        m.m_xy = -16384; m.m_yx = 16384;
        pending_mats.push_back(m);
        for (k = 0; k < 1500; k++) begin
            if ($urandom_range(0, 9) < 6) begin
                pending_mats.push_back(rand_rot());
            end else begin
                m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                     rand_elem(), rand_elem(), rand_elem(), rand_elem()};
                pending_mats.push_back(m);
            end
        end
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mat_ch.valid <= 1'b0;
            mat_ch.data  <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end else begin
            if (mat_ch.valid && mat_ch.ready) begin
                expected_quats.push_back(quat_of_mat(mat_ch.data));
                void'(pending_mats.pop_front());
            end
            if (mat_ch.valid && !mat_ch.ready) begin
                // hold the current request
            end else if (gap_left > 0) begin
                gap_left     <= gap_left - 1;
                mat_ch.valid <= 1'b0;
            end else if (pending_mats.size() > 0) begin
                mat_ch.valid <= 1'b1;
                mat_ch.data  <= pending_mats[0];
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                mat_ch.valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quat_ch.ready  <= 1'b0;
            stall_left     <= 0;
            long_hold      <= 0;
            long_hold_done <= 1'b0;
        end else begin
            if (!long_hold_done && cycle_count > HOLD_AT) begin
                long_hold_done <= 1'b1;
                long_hold      <= 150;
                quat_ch.ready  <= 1'b0;
            end else if (long_hold > 0) begin
                long_hold     <= long_hold - 1;
                quat_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left    <= stall_left - 1;
                quat_ch.ready <= 1'b0;
            end else if (cycle_count % 512 < 200 && $urandom_range(0, 3) == 0) begin
                stall_left    <= $urandom_range(0, 8);
                quat_ch.ready <= 1'b0;
            end else begin
                quat_ch.ready <= 1'b1;
            end
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n && quat_ch.valid && quat_ch.ready) begin
            if (expected_quats.size() == 0) begin
                $error("unexpected quaternion %h", quat_ch.data);
                err_count++;
            end else begin
                exp_q = expected_quats.pop_front();
                if (quat_ch.data.q_x !== exp_q.q_x) begin
                    $error("q_x expected %0d actual %0d", exp_q.q_x, quat_ch.data.q_x);
                    err_count++;
                end
                if (quat_ch.data.q_y !== exp_q.q_y) begin
                    $error("q_y expected %0d actual %0d", exp_q.q_y, quat_ch.data.q_y);
                    err_count++;
                end
                if (quat_ch.data.q_z !== exp_q.q_z) begin
                    $error("q_z expected %0d actual %0d", exp_q.q_z, quat_ch.data.q_z);
                    err_count++;
                end
                if (quat_ch.data.q_w !== exp_q.q_w) begin
                    $error("q_w expected %0d actual %0d", exp_q.q_w, quat_ch.data.q_w);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("tb_rotation_matrix_to_quaternion_top: errors");
            $finish;
        end
    end

    initial begin
        err_count   = 0;
        cycle_count = 0;
        i_rst_n     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (pending_mats.size() == 0 && !mat_ch.valid);
        wait (expected_quats.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (err_count == 0 && expected_quats.size() == 0) begin
            $display("tb_rotation_matrix_to_quaternion_top: clean");
        end else begin
            $display("tb_rotation_matrix_to_quaternion_top: errors");
        end
        $finish;
    end

endmodule
